/* hw/rtl/tbe_pkg.sv */
// Shared types and constants for the burst extraction and derotation core.
`timescale 1ns / 1ps
package tbe_pkg;

  localparam int unsigned SampleW   = 16;
  localparam int unsigned HistDepth = 256;
  localparam int unsigned HistAw    = $clog2(HistDepth);
  localparam int unsigned LenW      = 13;
  localparam int unsigned MaxBurst  = 4096;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 13;

  localparam logic [CfgIdxW-1:0] CfgLength  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgBackoff = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgCfoEn   = 2'd2;

  localparam logic signed [17:0] PhOne = 18'sd65536;

  typedef struct packed {
    logic clr;
    logic load;
    logic decide;
    logic nrm_start;
    logic mul1;
    logic mul2;
    logic fin;
  } tbe_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic burst_idle;
    logic mark;
    logic nrm_done;
    logic out_free;
  } tbe_sts_t;

endpackage

/* hw/rtl/tbe_rotnorm.sv */
// Rotation normalizer: iterative square root and two serial divisions.
`timescale 1ns / 1ps
module tbe_rotnorm import tbe_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [15:0] rot_re_i,
  input  logic signed [15:0] rot_im_i,
  output logic               done_o,
  output logic signed [15:0] step_re_o,
  output logic signed [15:0] step_im_o
);

  typedef enum logic [1:0] {N_IDLE, N_SQRT, N_LOAD, N_DIV} nrm_state_e;

  nrm_state_e         st_q;
  logic [63:0]        n_q, res_q, bit_q;
  logic [5:0]         cnt_q;
  logic               sel_q;
  logic [31:0]        q_q;
  logic [31:0]        rem_q;
  logic [46:0]        dvd_q;
  logic               done_q;
  logic signed [15:0] step_re_q, step_im_q;

  logic signed [31:0] sq_re, sq_im;
  logic [31:0]        m2;
  logic [63:0]        trial;
  logic [16:0]        abs_c;
  logic [32:0]        r2;
  logic [46:0]        dvd_d;
  logic [31:0]        rem_d;
  logic signed [17:0] v, sv_re, sv_im;
  logic signed [15:0] c_sel;

  function automatic logic signed [15:0] sat16(input logic signed [17:0] x);
    if (x > 18'sd32767) begin
      return 16'sh7FFF;
    end else if (x < -18'sd32768) begin
      return 16'sh8000;
    end
    return x[15:0];
  endfunction

  always_comb begin
    sq_re = rot_re_i * rot_re_i;
    sq_im = rot_im_i * rot_im_i;
    m2    = $unsigned(sq_re) + $unsigned(sq_im);
    trial = res_q + bit_q;
    c_sel = sel_q ? rot_im_i : rot_re_i;
    abs_c = c_sel[15] ? 17'(-{c_sel[15], c_sel}) : {1'b0, c_sel};
    r2    = {rem_q, dvd_q[46]};
    if (r2 >= {1'b0, q_q}) begin
      rem_d = 32'(r2 - {1'b0, q_q});
      dvd_d = {dvd_q[45:0], 1'b1};
    end else begin
      rem_d = r2[31:0];
      dvd_d = {dvd_q[45:0], 1'b0};
    end
    v     = {1'b0, dvd_d[16:0]};
    sv_re = rot_re_i[15] ? -v : v;
    sv_im = rot_im_i[15] ? v : -v;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= N_IDLE;
      done_q    <= 1'b0;
      step_re_q <= '0;
      step_im_q <= '0;
      cnt_q     <= '0;
      sel_q     <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (st_q)
        N_IDLE: begin
          if (start_i) begin
            if (m2 == '0) begin
              step_re_q <= 16'sh7FFF;
              step_im_q <= '0;
              done_q    <= 1'b1;
            end else begin
              n_q   <= {2'b00, m2, 30'd0};
              res_q <= '0;
              bit_q <= 64'h4000_0000_0000_0000;
              cnt_q <= 6'd31;
              st_q  <= N_SQRT;
            end
          end
        end
        N_SQRT: begin
          if (n_q >= trial) begin
            n_q   <= n_q - trial;
            res_q <= (res_q >> 1) + bit_q;
            q_q   <= 32'((res_q >> 1) + bit_q);
          end else begin
            res_q <= res_q >> 1;
            q_q   <= 32'(res_q >> 1);
          end
          bit_q <= bit_q >> 2;
          cnt_q <= cnt_q - 6'd1;
          if (cnt_q == '0) begin
            sel_q <= 1'b0;
            st_q  <= N_LOAD;
          end
        end
        N_LOAD: begin
          dvd_q <= {abs_c, 30'd0} + 47'(q_q >> 1);
          rem_q <= '0;
          cnt_q <= 6'd46;
          st_q  <= N_DIV;
        end
        N_DIV: begin
          rem_q <= rem_d;
          dvd_q <= dvd_d;
          cnt_q <= cnt_q - 6'd1;
          if (cnt_q == '0) begin
            if (!sel_q) begin
              step_re_q <= sat16(sv_re);
              sel_q     <= 1'b1;
              st_q      <= N_LOAD;
            end else begin
              step_im_q <= sat16(sv_im);
              done_q    <= 1'b1;
              st_q      <= N_IDLE;
            end
          end
        end
        default: st_q <= N_IDLE;
      endcase
    end
  end

  assign done_o    = done_q;
  assign step_re_o = step_re_q;
  assign step_im_o = step_im_q;

endmodule

/* hw/rtl/tbe_ctrl.sv */
// Controller state machine sequencing one sample beat through the datapath.
`timescale 1ns / 1ps
module tbe_ctrl import tbe_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  tbe_sts_t sts_i,
  output tbe_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_DECIDE, ST_NORM, ST_MUL1, ST_MUL2, ST_FIN
  } ctrl_state_e;

  ctrl_state_e state_q;

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_CLEAR:  cmd_o.clr = 1'b1;
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_DECIDE: begin
        cmd_o.decide    = 1'b1;
        cmd_o.nrm_start = sts_i.burst_idle & sts_i.mark;
      end
      ST_NORM:   ;
      ST_MUL1:   cmd_o.mul1 = 1'b1;
      ST_MUL2:   cmd_o.mul2 = 1'b1;
      ST_FIN:    cmd_o.fin = sts_i.out_free;
      default:   ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      unique case (state_q)
        ST_CLEAR:  if (sts_i.clr_done) state_q <= ST_IDLE;
        ST_IDLE:   if (in_valid_i) state_q <= ST_DECIDE;
        ST_DECIDE: begin
          if (!sts_i.burst_idle) begin
            state_q <= ST_MUL1;
          end else if (sts_i.mark) begin
            state_q <= ST_NORM;
          end else begin
            state_q <= ST_IDLE;
          end
        end
        ST_NORM:   if (sts_i.nrm_done) state_q <= ST_MUL1;
        ST_MUL1:   state_q <= ST_MUL2;
        ST_MUL2:   state_q <= ST_FIN;
        ST_FIN:    if (sts_i.out_free) state_q <= ST_IDLE;
        default:   state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

/* hw/rtl/tbe_datapath.sv */
// Datapath: history memory, burst state, scaling and derotation arithmetic.
`timescale 1ns / 1ps
module tbe_datapath import tbe_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  tbe_cmd_t                   cmd_i,
  output tbe_sts_t                   sts_o,
  input  logic                       cfg_we_i,
  input  logic [CfgIdxW-1:0]         cfg_idx_i,
  input  logic [CfgDataW-1:0]        cfg_data_i,
  input  logic signed [SampleW-1:0]  sample_re_i,
  input  logic signed [SampleW-1:0]  sample_im_i,
  input  logic                       burst_mark_i,
  input  logic [15:0]                gain_i,
  input  logic signed [15:0]         rot_re_i,
  input  logic signed [15:0]         rot_im_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic signed [SampleW-1:0]  out_re_o,
  output logic signed [SampleW-1:0]  out_im_o,
  output logic                       first_of_burst_o,
  output logic                       last_of_burst_o,
  output logic [31:0]                burst_index_o
);

  logic [LenW-1:0]  len_cfg_q;
  logic [7:0]       backoff_q;
  logic             cfo_q;

  logic [2*SampleW-1:0] hist_mem [HistDepth];
  logic [2*SampleW-1:0] rd_data_q;
  logic [HistAw-1:0]    wr_pos_q, clr_addr_q, rd_addr;
  logic                 bypass_q;

  logic signed [SampleW-1:0] in_re_q, in_im_q, x_re_q, x_im_q;
  logic                      mark_q;
  logic [15:0]               gain_in_q, gain_q;
  logic signed [15:0]        rot_re_q, rot_im_q;

  logic [LenW-1:0]    remaining_q, len_eff, rem_dec;
  logic               first_q;
  logic [31:0]        count_q;
  logic signed [17:0] ph_re_q, ph_im_q;
  logic signed [15:0] step_re, step_im;
  logic               nrm_done;

  logic signed [32:0] pr_q, pi_q;
  logic signed [50:0] p_rr_q, p_ii_q, p_ri_q, p_ir_q;
  logic signed [33:0] a_q, b_q, c_q, d_q;

  logic signed [51:0] s_re, s_im;
  logic signed [34:0] t_re, t_im;
  logic signed [33:0] n_re, n_im;
  logic signed [23:0] y_re, y_im;
  logic               out_valid_q;
  logic signed [SampleW-1:0] out_re_q, out_im_q;
  logic               out_first_q, out_last_q;
  logic [31:0]        out_idx_q;

  function automatic logic signed [15:0] sat16(input logic signed [23:0] x);
    if (x > 24'sd32767) begin
      return 16'sh7FFF;
    end else if (x < -24'sd32768) begin
      return 16'sh8000;
    end
    return x[15:0];
  endfunction

  function automatic logic signed [17:0] sat18(input logic signed [19:0] x);
    if (x > 20'sd131071) begin
      return 18'sh1FFFF;
    end else if (x < -20'sd131072) begin
      return 18'sh20000;
    end
    return x[17:0];
  endfunction

  tbe_rotnorm u_rotnorm (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cmd_i.nrm_start),
    .rot_re_i  (rot_re_q),
    .rot_im_i  (rot_im_q),
    .done_o    (nrm_done),
    .step_re_o (step_re),
    .step_im_o (step_im)
  );

  always_comb begin
    rd_addr = wr_pos_q - backoff_q;
    if (len_cfg_q == '0) begin
      len_eff = LenW'(1);
    end else if (len_cfg_q > LenW'(MaxBurst)) begin
      len_eff = LenW'(MaxBurst);
    end else begin
      len_eff = len_cfg_q;
    end
    rem_dec = remaining_q - LenW'(1);
    s_re = {p_rr_q[50], p_rr_q} - {p_ii_q[50], p_ii_q};
    s_im = {p_ri_q[50], p_ri_q} + {p_ir_q[50], p_ir_q};
    if (cfo_q) begin
      n_re = '0;
      n_im = '0;
      y_re = 24'((s_re + 52'sd134217728) >>> 28);
      y_im = 24'((s_im + 52'sd134217728) >>> 28);
    end else begin
      n_re = ($signed({pr_q[32], pr_q}) + 34'sd2048) >>> 12;
      n_im = ($signed({pi_q[32], pi_q}) + 34'sd2048) >>> 12;
      y_re = n_re[23:0];
      y_im = n_im[23:0];
    end
    t_re = {a_q[33], a_q} - {b_q[33], b_q};
    t_im = {c_q[33], c_q} + {d_q[33], d_q};
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_cfg_q <= LenW'(1024);
      backoff_q <= '0;
      cfo_q     <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgLength:  len_cfg_q <= cfg_data_i[LenW-1:0];
        CfgBackoff: backoff_q <= cfg_data_i[7:0];
        CfgCfoEn:   cfo_q     <= cfg_data_i[0];
        default:    ;
      endcase
    end
  end

  // history memory, swept to zero after reset
  always_ff @(posedge clk_i) begin
    if (cmd_i.clr) begin
      hist_mem[clr_addr_q] <= '0;
    end else if (cmd_i.load) begin
      hist_mem[wr_pos_q] <= {sample_re_i, sample_im_i};
    end
    if (cmd_i.load) begin
      rd_data_q <= hist_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q  <= '0;
      wr_pos_q    <= '0;
      remaining_q <= '0;
      first_q     <= 1'b0;
      count_q     <= '0;
      gain_q      <= '0;
      ph_re_q     <= '0;
      ph_im_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clr) begin
        clr_addr_q <= clr_addr_q + HistAw'(1);
      end
      if (cmd_i.load) begin
        wr_pos_q <= wr_pos_q + HistAw'(1);
      end
      if (cmd_i.decide && remaining_q == '0 && mark_q) begin
        remaining_q <= len_eff;
        gain_q      <= gain_in_q;
        ph_re_q     <= PhOne;
        ph_im_q     <= '0;
        first_q     <= 1'b1;
      end
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.fin) begin
        out_valid_q <= 1'b1;
        ph_re_q     <= sat18(t_re[34:15] + 20'(t_re[14]));
        ph_im_q     <= sat18(t_im[34:15] + 20'(t_im[14]));
        remaining_q <= rem_dec;
        first_q     <= 1'b0;
        if (rem_dec == '0) begin
          count_q <= count_q + 32'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      in_re_q   <= sample_re_i;
      in_im_q   <= sample_im_i;
      mark_q    <= burst_mark_i;
      gain_in_q <= gain_i;
      rot_re_q  <= rot_re_i;
      rot_im_q  <= rot_im_i;
      bypass_q  <= (backoff_q == '0);
    end
    if (cmd_i.decide) begin
      x_re_q <= bypass_q ? in_re_q : rd_data_q[2*SampleW-1:SampleW];
      x_im_q <= bypass_q ? in_im_q : rd_data_q[SampleW-1:0];
    end
    if (cmd_i.mul1) begin
      pr_q <= x_re_q * $signed({1'b0, gain_q});
      pi_q <= x_im_q * $signed({1'b0, gain_q});
    end
    if (cmd_i.mul2) begin
      p_rr_q <= pr_q * ph_re_q;
      p_ii_q <= pi_q * ph_im_q;
      p_ri_q <= pr_q * ph_im_q;
      p_ir_q <= pi_q * ph_re_q;
      a_q    <= ph_re_q * step_re;
      b_q    <= ph_im_q * step_im;
      c_q    <= ph_re_q * step_im;
      d_q    <= ph_im_q * step_re;
    end
    if (cmd_i.fin) begin
      out_re_q    <= sat16(y_re);
      out_im_q    <= sat16(y_im);
      out_first_q <= first_q;
      out_last_q  <= (rem_dec == '0);
      out_idx_q   <= count_q;
    end
  end

  assign sts_o.clr_done   = (clr_addr_q == '1);
  assign sts_o.burst_idle = (remaining_q == '0);
  assign sts_o.mark       = mark_q;
  assign sts_o.nrm_done   = nrm_done;
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o      = out_valid_q;
  assign out_re_o         = out_re_q;
  assign out_im_o         = out_im_q;
  assign first_of_burst_o = out_first_q;
  assign last_of_burst_o  = out_last_q;
  assign burst_index_o    = out_idx_q;

endmodule

/* hw/rtl/tagged_burst_extract_derotate_core.sv */
// Top level: burst extraction with gain scaling and carrier-offset derotation.
// Path: each burst sample passes load, decide, two multiply stages and the
// registered output; the first sample of a burst also waits for rotation
// normalization (a zero estimate skips the square root and divisions). A held
// output beat stalls the controller until it is taken. A new beat is accepted
// only after the last reaches the output; non-burst beats stop after decide.
// Reset: asynchronous; a sweep zeroes all 256 history entries before input is taken.
`timescale 1ns / 1ps
module tagged_burst_extract_derotate_core import tbe_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [CfgIdxW-1:0]        cfg_idx_i,
  input  logic [CfgDataW-1:0]       cfg_data_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic signed [SampleW-1:0] sample_re_i,
  input  logic signed [SampleW-1:0] sample_im_i,
  input  logic                      burst_mark_i,
  input  logic [15:0]               gain_i,
  input  logic signed [15:0]        rot_re_i,
  input  logic signed [15:0]        rot_im_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic signed [SampleW-1:0] out_re_o,
  output logic signed [SampleW-1:0] out_im_o,
  output logic                      first_of_burst_o,
  output logic                      last_of_burst_o,
  output logic [31:0]               burst_index_o
);

  tbe_cmd_t cmd;
  tbe_sts_t sts;

  tbe_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tbe_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .sample_re_i      (sample_re_i),
    .sample_im_i      (sample_im_i),
    .burst_mark_i     (burst_mark_i),
    .gain_i           (gain_i),
    .rot_re_i         (rot_re_i),
    .rot_im_i         (rot_im_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .out_re_o         (out_re_o),
    .out_im_o         (out_im_o),
    .first_of_burst_o (first_of_burst_o),
    .last_of_burst_o  (last_of_burst_o),
    .burst_index_o    (burst_index_o)
  );

endmodule
